// ----- design/stpl_pkg.sv -----
// Package for the sorted table predecessor lookup unit.
// Item and result types, field widths, codes and default sizes.
// No dependencies.
package stpl_pkg;

    localparam int INDEX_W          = 12;
    localparam int ADDR_IN_W        = 64;
    localparam int COUNT_W          = 13;
    localparam int STATUS_W         = 2;

    localparam int DEF_TABLE_DEPTH   = 4096;
    localparam int DEF_ADDRESS_WIDTH = 64;

    // item action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_KERNEL = 2'd2;

    typedef struct packed {
        logic                 action;
        logic [INDEX_W-1:0]   entry_index;
        logic [ADDR_IN_W-1:0] address;
    } stpl_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  symbol_index;
    } stpl_result_t;

endpackage

// ----- design/stpl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stpl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/stpl_search.sv -----
// Binary search sequencer: one table compare per cycle, special-case results.
// Depends on stpl_pkg; reads the table through a registered-read RAM port.
module stpl_search #(
    parameter int TABLE_DEPTH   = stpl_pkg::DEF_TABLE_DEPTH,
    parameter int ADDRESS_WIDTH = stpl_pkg::DEF_ADDRESS_WIDTH,
    localparam int IDX_W        = $clog2(TABLE_DEPTH),
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      launch,
    input  logic [ADDRESS_WIDTH-1:0]  query,
    input  logic [CNT_W-1:0]          count,
    output logic                      busy,
    output logic [IDX_W-1:0]          rd_addr,
    input  logic [ADDRESS_WIDTH-1:0]  rd_data,
    output logic                      done,
    output stpl_pkg::stpl_result_t    result
);
    import stpl_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [ADDRESS_WIDTH-1:0] query_reg;
    logic                     done_reg, done_next;
    stpl_result_t             result_reg, result_next;

    logic                     le;
    logic [CNT_W-1:0]         lo_upd, hi_upd, span, mid_upd, fin_idx;
    logic [31:0]              fin_wide;

    // shared compare and halving step
    always_comb
    begin
        le       = rd_data <= query_reg;
        lo_upd   = le ? mid_reg + CNT_W'(1) : lo_reg;
        hi_upd   = le ? hi_reg : mid_reg;
        span     = hi_upd - lo_upd;
        mid_upd  = lo_upd + (span >> 1);
        fin_idx  = (lo_upd != '0) ? lo_upd - CNT_W'(1) : '0;
        fin_wide = 32'(fin_idx);
    end

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                mid_next = count >> 1;
                if (launch)
                begin
                    lo_next = '0;
                    hi_next = count;
                    if (query == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ST_NOT_KERNEL, symbol_index: '0};
                    end
                    else if (count == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ST_NO_TABLE, symbol_index: '0};
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                lo_next  = lo_upd;
                hi_next  = hi_upd;
                mid_next = mid_upd;
                if (lo_upd >= hi_upd)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{status: ST_FOUND, symbol_index: fin_wide[INDEX_W-1:0]};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        result_reg <= result_next;
        if (launch && state_reg == S_IDLE)
        begin
            query_reg <= query;
        end
    end

    // read address follows the next midpoint so data lands for the next compare
    assign rd_addr = mid_next[IDX_W-1:0];
    assign busy    = state_reg == S_SEARCH;
    assign done    = done_reg;
    assign result  = result_reg;

endmodule

// ----- design/sorted_table_predecessor_lookup_unit.sv -----
// Order: a load item writes its table slot when accepted; a zero-address or empty-table lookup strobes its
// result in the cycle after acceptance; a search strobes it after its halving steps,
// up to ceil(log2(n+1)) steps for n entries (13 for 4096), through the done register.
// Loads and early-answered lookups are taken one item per cycle while busy is low; busy is high for
// the compare cycles, and no item is accepted then. Results cannot stall.
// Reset clears the control state and symbol_count; table contents are undefined.
module sorted_table_predecessor_lookup_unit #(
    parameter int TABLE_DEPTH   = stpl_pkg::DEF_TABLE_DEPTH,
    parameter int ADDRESS_WIDTH = stpl_pkg::DEF_ADDRESS_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  stpl_pkg::stpl_item_t                item,
    // result channel
    output logic                                done,
    output stpl_pkg::stpl_result_t              result,
    // symbol_count register
    input  logic                                count_we,
    input  logic [stpl_pkg::COUNT_W-1:0]        count_wdata
);
    import stpl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0]       symbol_count_reg;
    logic                     accept;
    logic                     load_we;
    logic                     launch;
    logic [ADDRESS_WIDTH-1:0] addr_cut;
    logic [31:0]              slot_wide;
    logic [31:0]              cnt_wide;
    logic [31:0]              cnt_sat;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         rd_addr;
    logic [ADDRESS_WIDTH-1:0] rd_data;

    // symbol_count must be written only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= '0;
        end
        else if (count_we)
        begin
            symbol_count_reg <= count_wdata;
        end
    end

    assign accept    = start && !busy;
    assign addr_cut  = item.address[ADDRESS_WIDTH-1:0];
    assign slot_wide = 32'(item.entry_index);

    // loads beyond the table are dropped
    assign load_we = accept && (item.action == ACT_LOAD) && (slot_wide < 32'(TABLE_DEPTH));
    assign launch  = accept && (item.action == ACT_LOOKUP);

    // a count above the depth saturates
    assign cnt_wide = 32'(symbol_count_reg);
    assign cnt_sat  = (cnt_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_wide;
    assign count    = cnt_sat[CNT_W-1:0];

    stpl_ram #(
        .WIDTH (ADDRESS_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_wide[IDX_W-1:0]),
        .wdata (addr_cut),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    stpl_search #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (launch),
        .query   (addr_cut),
        .count   (count),
        .busy    (busy),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- design/stpl_checker.sv -----
// Port-level checks for the sorted table predecessor lookup unit, with its bind.
// Depends on stpl_pkg and sorted_table_predecessor_lookup_unit.
module stpl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input stpl_pkg::stpl_item_t         item,
    input logic                         done,
    input stpl_pkg::stpl_result_t       result
);
    import stpl_pkg::*;

    // a result never shows while a search still runs
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a load item causes no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.action == ACT_LOAD) |=> !done)
        else $error("result after a load item");

    // zero query answers at once with not kernel
    a_zero_query: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.action == ACT_LOOKUP && item.address == '0)
        |=> (done && result.status == ST_NOT_KERNEL && result.symbol_index == '0))
        else $error("zero query not answered as not kernel");

    // only a lookup can start a search
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && item.action == ACT_LOOKUP))
        else $error("busy without a lookup item");

    // error statuses carry index 0
    a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_FOUND) |-> result.symbol_index == '0)
        else $error("non-zero index with error status");

endmodule

bind sorted_table_predecessor_lookup_unit stpl_checker u_stpl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
